### design/imusfc_pkg.sv
// imusfc_pkg: shared types and constants of the imu serial frame collector
// used by every module of the design folder; depends on nothing
`timescale 1ns / 1ps

package imusfc_pkg;

    // frame layout
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_KIND   = 4'd1;
    localparam logic [3:0] POS_DATA0  = 4'd2;
    localparam logic [3:0] POS_CHECK  = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ATTEMPTS  = 2'd0;
    localparam logic [1:0] CFG_ATTITUDE_TYPE = 2'd1;
    localparam logic [1:0] CFG_PRESSURE_TYPE = 2'd2;

    // configuration reset values
    localparam logic [6:0] MAX_ATTEMPTS_RST  = 7'd101;
    localparam logic [7:0] ATTITUDE_TYPE_RST = 8'h53;
    localparam logic [7:0] PRESSURE_TYPE_RST = 8'h56;

    // received mask bits
    localparam int unsigned MASK_ATT = 0;
    localparam int unsigned MASK_PRS = 1;

    // angle: floor(raw * 180 / 2^15)
    localparam logic signed [24:0] ANGLE_SCALE = 25'sd180;
    localparam int unsigned        ANGLE_SHIFT = 15;

    // temperature: trunc(raw * 5 / 17) + 3625, divide by 17 via reciprocal
    localparam int unsigned        TEMP_SHIFT  = 22;
    localparam logic [17:0]        TEMP_RECIP  = 18'(((64'd1 << TEMP_SHIFT)) / 64'd17);
    localparam logic [17:0]        TEMP_DIV    = 18'd17;
    localparam logic signed [14:0] TEMP_OFFSET = 15'sd3625;

    localparam int unsigned QUEUE_DEPTH = 2;

    // one collected record, raw words as they left the frames
    typedef struct packed {
        logic [3:0][15:0] att_words;
        logic [31:0]      alt_word;
        logic             att_valid;
        logic             prs_valid;
        logic             timed_out;
    } rec_t;

    // queue to back end handshake
    typedef struct packed {
        logic valid;
        rec_t rec;
    } rec_chan_t;

endpackage

### design/imusfc_front.sv
// imusfc_front: byte parser, checksum, attempt budget and record collection
// depends on imusfc_pkg
`timescale 1ns / 1ps

module imusfc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              push,
    output imusfc_pkg::rec_t  push_rec
);

    logic [6:0]       max_att_reg;
    logic [7:0]       att_type_reg;
    logic [7:0]       prs_type_reg;

    logic [3:0]       pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0][7:0]  pay_reg, pay_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [1:0]       mask_reg, mask_next;
    logic [3:0][15:0] att_reg, att_next;
    logic [31:0]      alt_reg, alt_next;

    logic             attempt;
    logic [6:0]       cnt_inc;
    logic [2:0]       pay_idx;
    logic [3:0]       pos_off;

    assign pos_off = pos_reg - imusfc_pkg::POS_DATA0;
    assign pay_idx = pos_off[2:0];
    assign cnt_inc = cnt_reg + 7'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_att_reg  <= imusfc_pkg::MAX_ATTEMPTS_RST;
            att_type_reg <= imusfc_pkg::ATTITUDE_TYPE_RST;
            prs_type_reg <= imusfc_pkg::PRESSURE_TYPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imusfc_pkg::CFG_MAX_ATTEMPTS:  max_att_reg  <= cfg_data[6:0];
                imusfc_pkg::CFG_ATTITUDE_TYPE: att_type_reg <= cfg_data;
                imusfc_pkg::CFG_PRESSURE_TYPE: prs_type_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= imusfc_pkg::POS_HEADER;
            sum_reg  <= 8'd0;
            cnt_reg  <= 7'd0;
            mask_reg <= 2'd0;
            att_reg  <= '0;
            alt_reg  <= 32'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            mask_reg <= mask_next;
            att_reg  <= att_next;
            alt_reg  <= alt_next;
        end
    end

    // frame kind and data bytes are always written before use
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        pay_reg  <= pay_next;
    end

    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        kind_next = kind_reg;
        pay_next  = pay_reg;
        cnt_next  = cnt_reg;
        mask_next = mask_reg;
        att_next  = att_reg;
        alt_next  = alt_reg;
        attempt   = 1'b0;
        push      = 1'b0;
        push_rec  = '0;

        if (in_fire)
        begin
            if (pos_reg == imusfc_pkg::POS_HEADER)
            begin
                if (rx_byte == imusfc_pkg::HDR_BYTE)
                begin
                    sum_next = imusfc_pkg::HDR_BYTE;
                    pos_next = imusfc_pkg::POS_KIND;
                end
                else
                begin
                    attempt = 1'b1;
                end
            end
            else if (pos_reg == imusfc_pkg::POS_KIND)
            begin
                kind_next = rx_byte;
                sum_next  = sum_reg + rx_byte;
                pos_next  = imusfc_pkg::POS_DATA0;
            end
            else if (pos_reg < imusfc_pkg::POS_CHECK)
            begin
                pay_next[pay_idx] = rx_byte;
                sum_next          = sum_reg + rx_byte;
                pos_next          = pos_reg + 4'd1;
            end
            else
            begin
                if (sum_reg == rx_byte)
                begin
                    if (kind_reg == att_type_reg)
                    begin
                        att_next[0] = {pay_reg[1], pay_reg[0]};
                        att_next[1] = {pay_reg[3], pay_reg[2]};
                        att_next[2] = {pay_reg[5], pay_reg[4]};
                        att_next[3] = {pay_reg[7], pay_reg[6]};
                        mask_next[imusfc_pkg::MASK_ATT] = 1'b1;
                    end
                    else if (kind_reg == prs_type_reg)
                    begin
                        alt_next = {pay_reg[3], pay_reg[2], pay_reg[1], pay_reg[0]};
                        mask_next[imusfc_pkg::MASK_PRS] = 1'b1;
                    end
                end
                pos_next = imusfc_pkg::POS_HEADER;
                sum_next = 8'd0;
                attempt  = 1'b1;
            end

            if (attempt)
            begin
                cnt_next = cnt_inc;
                if (mask_next == 2'b11)
                begin
                    push               = 1'b1;
                    push_rec.timed_out = 1'b0;
                end
                else if (cnt_inc >= max_att_reg)
                begin
                    push               = 1'b1;
                    push_rec.timed_out = 1'b1;
                end
            end

            push_rec.att_words = att_next;
            push_rec.alt_word  = alt_next;
            push_rec.att_valid = mask_next[imusfc_pkg::MASK_ATT];
            push_rec.prs_valid = mask_next[imusfc_pkg::MASK_PRS];

            if (push)
            begin
                cnt_next  = 7'd0;
                mask_next = 2'd0;
                att_next  = '0;
                alt_next  = 32'd0;
            end
        end
    end

endmodule

### design/imusfc_queue.sv
// imusfc_queue: short record queue between parser and arithmetic back end
// depends on imusfc_pkg
`timescale 1ns / 1ps

module imusfc_queue
#(
    parameter int unsigned DEPTH = imusfc_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  imusfc_pkg::rec_t      push_rec,
    output logic                  full,
    output imusfc_pkg::rec_chan_t head,
    input  logic                  pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    imusfc_pkg::rec_t ent_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign head.valid = (cnt_reg != '0);
    assign head.rec   = ent_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

### design/imusfc_back.sv
// imusfc_back: two-stage scaling of angles and temperature, output register
// depends on imusfc_pkg
`timescale 1ns / 1ps

module imusfc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  imusfc_pkg::rec_chan_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [8:0]     pitch_deg,
    output logic signed [8:0]     roll_deg,
    output logic signed [8:0]     yaw_deg,
    output logic signed [14:0]    temperature_centi,
    output logic signed [31:0]    pressure_altitude,
    output logic                  attitude_valid,
    output logic                  pressure_valid,
    output logic                  timed_out
);

    // stage 1 registers
    logic                    s1_valid_reg;
    logic signed [2:0][24:0] s1_ang_reg;
    logic [35:0]             s1_tprod_reg;
    logic [17:0]             s1_tx_reg;
    logic                    s1_tneg_reg;
    logic [31:0]             s1_alt_reg;
    logic                    s1_attv_reg;
    logic                    s1_prsv_reg;
    logic                    s1_timed_reg;

    logic                    out_valid_reg;
    logic signed [8:0]       pitch_reg, roll_reg, yaw_reg;
    logic signed [14:0]      temp_reg;
    logic [31:0]             alt_reg;
    logic                    attv_reg, prsv_reg, timed_reg;

    logic                    out_free;
    logic                    s1_adv;

    logic signed [2:0][24:0] ang_prod;
    logic [15:0]             traw;
    logic [16:0]             tsx;
    logic [16:0]             tabs;
    logic [17:0]             tx;
    logic [35:0]             tprod;

    logic [13:0]             q0;
    logic [17:0]             rem;
    logic [13:0]             quo;
    logic signed [14:0]      temp_val;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || out_free;
    assign pop      = s1_adv;

    // stage 1: the multiplications
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ang_prod[i] = $signed({{9{head.rec.att_words[i][15]}}, head.rec.att_words[i]})
                          * imusfc_pkg::ANGLE_SCALE;
        traw  = head.rec.att_words[3];
        tsx   = {traw[15], traw};
        tabs  = traw[15] ? 17'(17'd0 - tsx) : tsx;
        tx    = 18'({tabs, 2'b00}) + 18'(tabs);
        tprod = 36'(tx) * 36'(imusfc_pkg::TEMP_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_adv)
            s1_valid_reg <= head.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_ang_reg   <= ang_prod;
            s1_tprod_reg <= tprod;
            s1_tx_reg    <= tx;
            s1_tneg_reg  <= traw[15];
            s1_alt_reg   <= head.rec.alt_word;
            s1_attv_reg  <= head.rec.att_valid;
            s1_prsv_reg  <= head.rec.prs_valid;
            s1_timed_reg <= head.rec.timed_out;
        end
    end

    // stage 2: reciprocal correction, sign and offset
    always_comb
    begin
        q0       = s1_tprod_reg[imusfc_pkg::TEMP_SHIFT +: 14];
        rem      = s1_tx_reg - 18'({q0, 4'b0000}) - 18'(q0);
        quo      = (rem >= imusfc_pkg::TEMP_DIV) ? q0 + 14'd1 : q0;
        temp_val = s1_tneg_reg ? imusfc_pkg::TEMP_OFFSET - $signed({1'b0, quo})
                               : imusfc_pkg::TEMP_OFFSET + $signed({1'b0, quo});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            pitch_reg <= s1_attv_reg ? 9'(s1_ang_reg[0] >>> imusfc_pkg::ANGLE_SHIFT) : '0;
            roll_reg  <= s1_attv_reg ? 9'(s1_ang_reg[1] >>> imusfc_pkg::ANGLE_SHIFT) : '0;
            yaw_reg   <= s1_attv_reg ? 9'(s1_ang_reg[2] >>> imusfc_pkg::ANGLE_SHIFT) : '0;
            temp_reg  <= s1_attv_reg ? temp_val : '0;
            alt_reg   <= s1_prsv_reg ? s1_alt_reg : 32'd0;
            attv_reg  <= s1_attv_reg;
            prsv_reg  <= s1_prsv_reg;
            timed_reg <= s1_timed_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pitch_deg         = pitch_reg;
    assign roll_deg          = roll_reg;
    assign yaw_deg           = yaw_reg;
    assign temperature_centi = temp_reg;
    assign pressure_altitude = $signed(alt_reg);
    assign attitude_valid    = attv_reg;
    assign pressure_valid    = prsv_reg;
    assign timed_out         = timed_reg;

endmodule

### design/imu_serial_frame_collector.sv
// imu_serial_frame_collector: one rx byte per transaction, one record per emission
// a completed record passes through the queue, the scale stage register and the output register
// throughput: one byte per cycle; in_ready drops only while the record queue is full
// reset: async active low; parser waits for a header, collection and queue empty,
// registers return to 101 attempts, attitude type 0x53, pressure type 0x56
`timescale 1ns / 1ps

module imu_serial_frame_collector
#(
    parameter int unsigned QUEUE_DEPTH = imusfc_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,

    // byte input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,

    // record output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [8:0]  pitch_deg,
    output logic signed [8:0]  roll_deg,
    output logic signed [8:0]  yaw_deg,
    output logic signed [14:0] temperature_centi,
    output logic signed [31:0] pressure_altitude,
    output logic               attitude_valid,
    output logic               pressure_valid,
    output logic               timed_out,

    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    logic                  in_fire;
    logic                  push;
    imusfc_pkg::rec_t      push_rec;
    logic                  q_full;
    imusfc_pkg::rec_chan_t head;
    logic                  pop;

    // a byte may finish a record on any cycle, so hold off while no slot is free
    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    // front: frame parsing, checksum, attempt budget, record snapshot
    imusfc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .rx_byte  (rx_byte),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .push_rec (push_rec)
    );

    // decouples the parser from a stalled output
    imusfc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_rec(push_rec),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    // back: angle and temperature scaling into the output register
    imusfc_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pitch_deg        (pitch_deg),
        .roll_deg         (roll_deg),
        .yaw_deg          (yaw_deg),
        .temperature_centi(temperature_centi),
        .pressure_altitude(pressure_altitude),
        .attitude_valid   (attitude_valid),
        .pressure_valid   (pressure_valid),
        .timed_out        (timed_out)
    );

    // a complete record never reports a timeout
    a_no_timeout_when_complete: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timed_out && attitude_valid && pressure_valid)
    ) else $error("complete record flagged as timed out");

    // missing attitude frame reads zero
    a_att_zero_when_missing: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !attitude_valid) |->
            (pitch_deg == 9'sd0 && roll_deg == 9'sd0 && yaw_deg == 9'sd0
             && temperature_centi == 15'sd0)
    ) else $error("attitude fields nonzero without attitude frame");

    // missing pressure frame reads zero
    a_prs_zero_when_missing: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !pressure_valid) |-> (pressure_altitude == 32'sd0)
    ) else $error("altitude nonzero without pressure frame");

    // every record carries both frames or a timeout
    a_record_has_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (timed_out || (attitude_valid && pressure_valid))
    ) else $error("record emitted without cause");

endmodule
